// File: sv/lef_pkg.sv
// Shared types and constants for the 3x3 Laplacian edge filter.
// Used by every module of the filter; depends on nothing else.
package lef_pkg;

  localparam int PIX_W     = 16;
  localparam int COORD_W   = 11;
  localparam int VAL_W     = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int LAP_SHIFT = 3;  // Centre weight of eight.

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [VAL_W-1:0] BORDER_VAL = 8'd255;

  // Position and case flags of one pixel, worked out when it is accepted.
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] row_m1;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] col_m1;
    logic               i_zero;
    logic               i_ge2;
    logic               j_zero;
    logic               j_ge2;
    logic               j_last;
    logic               w_ge2;
    logic               i_last;
    logic               h_one;
  } pos_t;

  // One filtered output pixel.
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [VAL_W-1:0]   value;
    logic               eoi;
  } res_t;

endpackage

// File: sv/lef_line_store.sv
// Line store: the two previous image rows packed into one synchronous memory.
// Depends on lef_pkg for the pixel width.
module lef_line_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [2*lef_pkg::PIX_W-1:0] wr_data,
  output logic [2*lef_pkg::PIX_W-1:0] rd_data
);
  import lef_pkg::*;

  logic [2*PIX_W-1:0] mem [DEPTH];
  logic [2*PIX_W-1:0] rd_q_r;
  logic [2*PIX_W-1:0] fwd_data_r;
  logic               fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // A read of the entry being written in the same cycle sees the new data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (rd_addr == wr_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;

endmodule

// File: sv/lef_window.sv
// 3x3 window of the two previous columns and the Laplacian with clamping.
// Depends on lef_pkg for pixel and result widths.
module lef_window (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic [lef_pkg::PIX_W-1:0] nu,
  input  logic [lef_pkg::PIX_W-1:0] nm,
  input  logic [lef_pkg::PIX_W-1:0] px,
  output logic [lef_pkg::VAL_W-1:0] lap
);
  import lef_pkg::*;

  localparam int NS_W  = PIX_W + 3;
  localparam int LAP_W = PIX_W + LAP_SHIFT + 1;

  // Entries 0..2 hold column j-2 (upper, middle, lower), 3..5 column j-1.
  logic [PIX_W-1:0]        wc_r [6];
  logic [NS_W-1:0]         nsum;
  logic signed [LAP_W-1:0] diff;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      wc_r[0] <= wc_r[3];
      wc_r[1] <= wc_r[4];
      wc_r[2] <= wc_r[5];
      wc_r[3] <= nu;
      wc_r[4] <= nm;
      wc_r[5] <= px;
    end
  end

  always_comb begin
    nsum = NS_W'(wc_r[0]) + NS_W'(wc_r[1]) + NS_W'(wc_r[2]) + NS_W'(wc_r[3])
         + NS_W'(wc_r[5]) + NS_W'(nu) + NS_W'(nm) + NS_W'(px);
    diff = $signed({1'b0, wc_r[4], LAP_SHIFT'(0)}) - $signed({1'b0, nsum});
    priority if (diff[LAP_W-1]) begin
      lap = '0;
    end else if (|diff[LAP_W-2:VAL_W]) begin
      lap = BORDER_VAL;
    end else begin
      lap = diff[VAL_W-1:0];
    end
  end

endmodule

// File: sv/lef_out_seq.sv
// Output sequencer: holds the up to three results of one pixel and hands
// them out one transaction at a time. Depends on lef_pkg for res_t.
module lef_out_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  lef_pkg::res_t               cand [3],
  input  logic [2:0]                  cand_vld,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [lef_pkg::COORD_W-1:0] out_row,
  output logic [lef_pkg::COORD_W-1:0] out_col,
  output logic [lef_pkg::VAL_W-1:0]   out_value,
  output logic                        out_last_of_run,
  output logic                        out_end_of_image,
  output logic                        free
);
  import lef_pkg::*;

  res_t       slot_r [3];
  logic [2:0] mask_r;
  logic [2:0] mask_nxt;
  logic [2:0] sel;
  logic [2:0] rest;
  logic       out_acc;
  res_t       cur;

  always_comb begin
    priority if (mask_r[0]) begin
      sel = 3'b001;
      cur = slot_r[0];
    end else if (mask_r[1]) begin
      sel = 3'b010;
      cur = slot_r[1];
    end else begin
      sel = 3'b100;
      cur = slot_r[2];
    end
    rest     = mask_r & ~sel;
    out_acc  = out_valid && !out_stall;
    free     = (mask_r == 3'b000) || (out_acc && (rest == 3'b000));
    mask_nxt = load ? cand_vld : (out_acc ? rest : mask_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 3'b000;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= cand;
    end
  end

  assign out_valid        = |mask_r;
  assign out_row          = cur.row;
  assign out_col          = cur.col;
  assign out_value        = cur.value;
  assign out_end_of_image = cur.eoi;
  assign out_last_of_run  = (rest == 3'b000);

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("result bundle loaded over pending results");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_last_of_run |=> out_valid)
    else $error("result run cut short");

endmodule

// File: sv/laplacian_edge_filter_3x3.sv
// 3x3 eight-neighbour Laplacian edge filter on a raster pixel stream.
// Uses lef_pkg, lef_line_store, lef_window and lef_out_seq.
//
// Usage:
//   Pixels enter in raster order on in_valid/in_stall/in_pixel; a transaction
//   takes place when in_valid is high and in_stall is low. Each pixel causes
//   zero to three results on out_valid/out_stall with the output coordinates,
//   the clamped response (255 on the border), a last-of-run flag on the final
//   result of each pixel and an end-of-image flag on pixel (H-1, W-1).
//   Image size is written through cfg_valid/cfg_ready/cfg_index/cfg_data
//   (index 0 width, 1 height) while no pixel is in flight; zero is taken as 1
//   and values above MAX_WIDTH or MAX_HEIGHT as the maximum.
// Timing:
//   An accepted pixel is registered in the compute stage, and its results are
//   loaded into the output register once that register is free.
//   One pixel per cycle is taken while each pixel causes at most one result
//   and out_stall is low; otherwise the input is held while the output
//   register hands the results out. The line store takes one read and one
//   write per pixel, with write data forwarded to a read of the same column.
// Reset:
//   Counters restart at pixel (0,0), the size returns to 2048 x 2048 (limited
//   to the maximum) and no result is pending. The line memory needs no
//   clearing pass. When out_stall is high the held result stays in place and
//   in_stall rises once the pixel behind it waits in the compute stage.
module laplacian_edge_filter_3x3 #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lef_pkg::PIX_W-1:0]   in_pixel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lef_pkg::COORD_W-1:0] out_row,
  output logic [lef_pkg::COORD_W-1:0] out_col,
  output logic [lef_pkg::VAL_W-1:0]   out_value,
  output logic                        out_last_of_run,
  output logic                        out_end_of_image,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lef_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lef_pkg::CFG_W-1:0]   cfg_data
);
  import lef_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int W_RST = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
  localparam int H_RST = (MAX_HEIGHT < 2048) ? MAX_HEIGHT : 2048;

  // Sizes are kept as size minus one, already limited to the legal range.
  logic [AW-1:0] wm1_r, wm1_nxt;
  logic [RW-1:0] hm1_r, hm1_nxt;
  logic [AW-1:0] cfg_wm1;
  logic [RW-1:0] cfg_hm1;

  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] j0;
  logic [RW-1:0] i0;
  pos_t          pos0;
  logic          accept;

  logic          s1_valid_r, s1_valid_nxt;
  pos_t          s1_pos_r;
  logic [AW-1:0] s1_addr_r;
  logic [PIX_W-1:0] s1_px_r;
  logic          s1_adv;

  logic [2*PIX_W-1:0] line_rd;
  logic [PIX_W-1:0]   nu;
  logic [PIX_W-1:0]   nm;
  logic [VAL_W-1:0]   lap;
  res_t               cand [3];
  logic [2:0]         cand_vld;
  logic               ob_free;

  // Configuration registers.
  always_comb begin
    cfg_wm1 = (cfg_data == '0) ? '0 :
              (32'(cfg_data) > MAX_WIDTH) ? AW'(MAX_WIDTH - 1) : AW'(cfg_data - CFG_W'(1));
    cfg_hm1 = (cfg_data == '0) ? '0 :
              (32'(cfg_data) > MAX_HEIGHT) ? RW'(MAX_HEIGHT - 1) : RW'(cfg_data - CFG_W'(1));
    wm1_nxt = wm1_r;
    hm1_nxt = hm1_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  wm1_nxt = cfg_wm1;
        REG_IMAGE_HEIGHT: hm1_nxt = cfg_hm1;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r <= AW'(W_RST - 1);
      hm1_r <= RW'(H_RST - 1);
    end else begin
      wm1_r <= wm1_nxt;
      hm1_r <= hm1_nxt;
    end
  end

  // Input side: position of the arriving pixel and the raster counters.
  assign s1_adv   = s1_valid_r && ob_free;
  assign in_stall = s1_valid_r && !ob_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    j0 = (col_r > wm1_r) ? '0 : col_r;
    i0 = (row_r > hm1_r) ? '0 : row_r;

    pos0.row    = COORD_W'(i0);
    pos0.row_m1 = COORD_W'(i0 - RW'(1));
    pos0.col    = COORD_W'(j0);
    pos0.col_m1 = COORD_W'(j0 - AW'(1));
    pos0.i_zero = (i0 == '0);
    pos0.i_ge2  = (i0 > RW'(1));
    pos0.j_zero = (j0 == '0);
    pos0.j_ge2  = (j0 > AW'(1));
    pos0.j_last = (j0 == wm1_r);
    pos0.w_ge2  = (wm1_r != '0);
    pos0.i_last = (i0 == hm1_r);
    pos0.h_one  = (hm1_r == '0);

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (j0 == wm1_r) begin
        col_nxt = '0;
        row_nxt = (i0 == hm1_r) ? '0 : i0 + RW'(1);
      end else begin
        col_nxt = j0 + AW'(1);
        row_nxt = i0;
      end
    end

    s1_valid_nxt = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r  <= pos0;
      s1_addr_r <= j0;
      s1_px_r   <= in_pixel;
    end
  end

  // Upper row in the high half, middle row in the low half.
  lef_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (j0),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr_r),
    .wr_data ({nm, s1_px_r}),
    .rd_data (line_rd)
  );

  assign nu = line_rd[2*PIX_W-1:PIX_W];
  assign nm = line_rd[PIX_W-1:0];

  lef_window u_window (
    .clk      (clk),
    .shift_en (s1_adv),
    .nu       (nu),
    .nm       (nm),
    .px       (s1_px_r),
    .lap      (lap)
  );

  // Results in output order. The first row, the left border of the row
  // above and an interior pixel exclude each other, so they share one slot.
  always_comb begin
    priority if (s1_pos_r.i_zero) begin
      cand[0] = '{row: '0, col: s1_pos_r.col, value: BORDER_VAL,
                  eoi: s1_pos_r.h_one && s1_pos_r.j_last};
    end else if (s1_pos_r.j_zero) begin
      cand[0] = '{row: s1_pos_r.row_m1, col: '0, value: BORDER_VAL, eoi: 1'b0};
    end else begin
      cand[0] = '{row: s1_pos_r.row_m1, col: s1_pos_r.col_m1, value: lap, eoi: 1'b0};
    end
    cand[1] = '{row: s1_pos_r.row_m1, col: s1_pos_r.col, value: BORDER_VAL, eoi: 1'b0};
    cand[2] = '{row: s1_pos_r.row, col: s1_pos_r.col, value: BORDER_VAL,
                eoi: s1_pos_r.j_last};
    cand_vld[0] = s1_pos_r.i_zero ||
                  (s1_pos_r.i_ge2 && (s1_pos_r.j_zero || s1_pos_r.j_ge2));
    cand_vld[1] = s1_pos_r.i_ge2 && s1_pos_r.j_last && s1_pos_r.w_ge2;
    cand_vld[2] = s1_pos_r.i_last && !s1_pos_r.i_zero;
  end

  lef_out_seq u_out_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (s1_adv),
    .cand             (cand),
    .cand_vld         (cand_vld),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_value        (out_value),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_image (out_end_of_image),
    .free             (ob_free)
  );

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted pixel did not reach the compute stage");

  a_eoi_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_image |-> out_last_of_run)
    else $error("end of image flagged on a result that is not last of its run");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_addr_r))
    else $error("compute stage lost a waiting pixel");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for laplacian_edge_filter_3x3: random pixel images under random
// sender gaps and receiver stalls, checked against an in-bench filter prediction.
// Depends on lef_pkg and the laplacian_edge_filter_3x3 RTL.
module testbench;
  import lef_pkg::*;

  localparam int MAX_W         = 2048;
  localparam int MAX_H         = 2048;
  localparam int CENTER_WEIGHT = 8;
  localparam int RANDOM_PIXELS = 340;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [VAL_W-1:0]   value;
    logic               last;
    logic               eoi;
  } filtered_pix_t;

  typedef enum int {PIX_FULL, PIX_DIM, PIX_SPIKY} pix_style_e;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COORD_W-1:0]   out_row;
  logic [COORD_W-1:0]   out_col;
  logic [VAL_W-1:0]     out_value;
  logic                 out_last_of_run;
  logic                 out_end_of_image;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Prediction state: line buffers, 3x3 window columns, raster position and size registers.
  logic [PIX_W-1:0] upper_buf [MAX_W] = '{default: '0};
  logic [PIX_W-1:0] middle_buf [MAX_W] = '{default: '0};
  logic [PIX_W-1:0] win_col [6] = '{default: '0};
  int unsigned      next_row = 0;
  int unsigned      next_col = 0;
  logic [CFG_W-1:0] width_reg = 12'd2048;
  logic [CFG_W-1:0] height_reg = 12'd2048;

  logic [PIX_W-1:0] pixel_q [$];
  filtered_pix_t    filtered_q [$];

  int          errors = 0;
  int          cycle_count = 0;
  int          pix_accepted = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  int          hold_mark = 40;
  int          mode_left = 0;
  int          stall_tick = 0;
  stall_mode_e stall_mode = STALL_NONE;

  laplacian_edge_filter_3x3 #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel        (in_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run),
    .out_end_of_image(out_end_of_image),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  task automatic report_error(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      report_error($sformatf("%s expected %0d got %0d", name, want, got));
    end
  endtask

  function automatic int unsigned eff_size(input int unsigned v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic filtered_pix_t pix_out(input int unsigned r, input int unsigned c,
                                            input int unsigned v, input logic eoi);
    filtered_pix_t o;
    o.row   = r[COORD_W-1:0];
    o.col   = c[COORD_W-1:0];
    o.value = v[VAL_W-1:0];
    o.last  = 1'b0;
    o.eoi   = eoi;
    return o;
  endfunction

  // Advances the filter by one pixel and appends the filtered pixels it releases.
  function automatic void filter_pixel(input logic [PIX_W-1:0] px);
    int unsigned      w;
    int unsigned      h;
    int unsigned      i;
    int unsigned      j;
    int               lap;
    logic [PIX_W-1:0] up_px;
    logic [PIX_W-1:0] mid_px;
    filtered_pix_t    run [$];
    w = eff_size(32'(width_reg), MAX_W);
    h = eff_size(32'(height_reg), MAX_H);
    // A size change can leave the position outside the new frame.
    if (next_col >= w) next_col = 0;
    if (next_row >= h) next_row = 0;
    i = next_row;
    j = next_col;
    up_px  = upper_buf[j];
    mid_px = middle_buf[j];
    if (i == 0) run.push_back(pix_out(0, j, BORDER_VAL, h == 1 && j == w - 1));
    if (i >= 2) begin
      if (j == 0) run.push_back(pix_out(i - 1, 0, BORDER_VAL, 1'b0));
      if (j >= 2) begin
        lap = CENTER_WEIGHT * int'(win_col[4]) - int'(win_col[0]) - int'(win_col[1])
              - int'(win_col[2]) - int'(win_col[3]) - int'(win_col[5])
              - int'(up_px) - int'(mid_px) - int'(px);
        if (lap < 0) lap = 0;
        if (lap > 255) lap = 255;
        run.push_back(pix_out(i - 1, j - 1, lap, 1'b0));
      end
      if (j == w - 1 && w >= 2) run.push_back(pix_out(i - 1, w - 1, BORDER_VAL, 1'b0));
    end
    if (i == h - 1 && i != 0) run.push_back(pix_out(i, j, BORDER_VAL, j == w - 1));
    win_col[0] = win_col[3];
    win_col[1] = win_col[4];
    win_col[2] = win_col[5];
    win_col[3] = up_px;
    win_col[4] = mid_px;
    win_col[5] = px;
    upper_buf[j]  = mid_px;
    middle_buf[j] = px;
    if (j >= w - 1) begin
      next_col = 0;
      next_row = (i >= h - 1) ? 0 : i + 1;
    end else begin
      next_col = j + 1;
    end
    if (run.size() != 0) run[run.size() - 1].last = 1'b1;
    foreach (run[k]) filtered_q.push_back(run[k]);
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel(input pix_style_e style);
    case (style)
      PIX_FULL: return PIX_W'($urandom);
      PIX_DIM:  return PIX_W'($urandom_range(0, 48));
      default: begin
        if ($urandom_range(0, 7) == 0) begin
          return ($urandom_range(0, 1) == 0) ? 16'hFFFF : PIX_W'($urandom);
        end
        return PIX_W'($urandom_range(0, 40));
      end
    endcase
  endfunction

  function automatic void queue_pixel(input logic [PIX_W-1:0] px);
    filter_pixel(px);
    pixel_q.push_back(px);
  endfunction

  // Feeds pixels until the raster position wraps back to the top left corner.
  function automatic void finish_image(input pix_style_e style);
    while (next_row != 0 || next_col != 0) queue_pixel(random_pixel(style));
  endfunction

  // Called at a rising edge with the filter idle; writes both size registers.
  task automatic set_size(input int unsigned w, input int unsigned h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    width_reg = w[CFG_W-1:0];
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    height_reg = h[CFG_W-1:0];
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Pixels with no result may still be inside the filter, hence the settle time.
  task automatic wait_idle();
    do @(posedge clk); while (pixel_q.size() != 0 || in_valid || filtered_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixel sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_pixel   <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        void'(pixel_q.pop_front());
        pix_accepted <= pix_accepted + 1;
      end
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
      end
      if (burst_left != 0 && pixel_q.size() != 0) begin
        in_valid   <= 1'b1;
        in_pixel   <= pixel_q[0];
        burst_left = burst_left - 1;
      end else begin
        in_valid <= 1'b0;
        if (burst_left == 0) gap_left = gap_left - 1;
      end
    end
  end

  // Receiver stall: a changing pattern, plus long hold-offs so the filter backs up.
  always @(posedge clk) begin
    logic stall_next;
    stall_next = 1'b0;
    if (!rst_n) begin
      hold_left = 0;
      mode_left = 0;
    end else if (hold_left != 0) begin
      stall_next = 1'b1;
      hold_left  = hold_left - 1;
    end else if (pix_accepted >= hold_mark) begin
      stall_next = 1'b1;
      hold_left  = 150;
      hold_mark  = hold_mark + 200;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 200);
      end
      mode_left  = mode_left - 1;
      stall_tick = stall_tick + 1;
      case (stall_mode)
        STALL_NONE:     stall_next = 1'b0;
        STALL_LIGHT:    stall_next = ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    stall_next = ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: stall_next = (stall_tick % 3 == 0);
        default:        stall_next = 1'b0;
      endcase
    end
    out_stall <= stall_next;
  end

  // Result checker: each transaction is compared with the oldest predicted pixel.
  always @(posedge clk) begin
    filtered_pix_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_q.size() == 0) begin
        report_error($sformatf("unexpected result at row %0d col %0d", out_row, out_col));
      end else begin
        want = filtered_q.pop_front();
        check_field("row", 16'(want.row), 16'(out_row));
        check_field("col", 16'(want.col), 16'(out_col));
        check_field("value", 16'(want.value), 16'(out_value));
        check_field("last_of_run", 16'(want.last), 16'(out_last_of_run));
        check_field("end_of_image", 16'(want.eoi), 16'(out_end_of_image));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ERROR: timeout with %0d results outstanding", $time, filtered_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned w;
    int unsigned h;
    int          images;
    int          random_done;
    pix_style_e  style;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset size of 2048 x 2048: first row only.
    queue_pixel(16'h0000); queue_pixel(16'hFFFF); queue_pixel(16'h5555); queue_pixel(16'hAAAA);
    wait_idle();
    // Out-of-range registers: width above the maximum, height zero.
    set_size(4095, 0);
    queue_pixel(16'h0001); queue_pixel(16'h8000); queue_pixel(16'h7FFF);
    wait_idle();
    // Width zero and height above the maximum; column counter falls outside the frame.
    set_size(0, 4095);
    repeat (5) queue_pixel(random_pixel(PIX_FULL));
    wait_idle();
    // Row counter outside the new height; two rows and a bit, with a response that saturates high.
    set_size(5, 5);
    queue_pixel(16'h0000); queue_pixel(16'h0000); queue_pixel(16'h0000);
    queue_pixel(16'hFFFF); queue_pixel(16'h0000);
    queue_pixel(16'h0000); queue_pixel(16'hFFFF); queue_pixel(16'h0000);
    queue_pixel(16'h0001); queue_pixel(16'h0000);
    queue_pixel(16'h0000); queue_pixel(16'h0000); queue_pixel(16'h0000);
    wait_idle();
    // Narrower width mid-image, then a shorter height mid-image.
    set_size(3, 5);
    queue_pixel(16'd100); queue_pixel(16'd3); queue_pixel(16'd0); queue_pixel(16'd200);
    wait_idle();
    set_size(3, 2);
    finish_image(PIX_DIM);
    wait_idle();

    random_done = 0;
    while (random_done < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0: begin w = 1; h = $urandom_range(1, 10); end
        1: begin w = $urandom_range(1, 16); h = 1; end
        2: begin w = 2; h = $urandom_range(1, 8); end
        3: begin w = $urandom_range(1, 12); h = 2; end
        4: begin w = $urandom_range(30, 70); h = 3; end
        default: begin w = $urandom_range(3, 10); h = $urandom_range(3, 8); end
      endcase
      set_size(w, h);
      images = 1 + 60 / (w * h);
      repeat (images) begin
        style = pix_style_e'($urandom_range(0, 2));
        repeat (w * h) queue_pixel(random_pixel(style));
      end
      random_done = random_done + images * w * h;
      wait_idle();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
